### hw/rtl/dof_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dof_pkg
// Shared types and constants of the dhcp option finder: beat structs, parse
// phases, option codes and result status codes.
// ----------------------------------------------------------------------------
package dof_pkg;

  localparam int unsigned IDX_W = 11;
  localparam int unsigned LEN_W = 12;

  localparam logic [LEN_W-1:0] FILE_AREA_BYTES  = 12'd128;
  localparam logic [LEN_W-1:0] SNAME_AREA_BYTES = 12'd64;

  localparam logic [1:0] REGION_OPTIONS = 2'd0;
  localparam logic [1:0] REGION_FILE    = 2'd1;
  localparam logic [1:0] REGION_SNAME   = 2'd2;

  localparam logic [1:0] OVL_FILE_BIT  = 2'b01;
  localparam logic [1:0] OVL_SNAME_BIT = 2'b10;

  localparam logic [7:0] CODE_PAD      = 8'd0;
  localparam logic [7:0] CODE_OVERLOAD = 8'd52;
  localparam logic [7:0] CODE_END      = 8'd255;

  localparam logic [1:0] ST_VALUE     = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_WALK      = 7'b0000010,
    PH_LEN_MATCH = 7'b0000100,
    PH_VALUE     = 7'b0001000,
    PH_LEN_SKIP  = 7'b0010000,
    PH_LEN_OVER  = 7'b0100000,
    PH_FLAG_OVER = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] region;
    logic       packet_start;
    logic       region_last;
    logic [7:0] search_code;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic [1:0] status;
    logic       last_result;
  } out_beat_t;

  typedef struct packed {
    logic      emit;
    out_beat_t beat;
  } step_res_t;

endpackage

### hw/rtl/dof_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dof_in_stage
// Input register: holds one accepted beat until the parser consumes it.
// ----------------------------------------------------------------------------
module dof_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dof_pkg::in_beat_t in_beat,
  input  logic              out_free,
  output logic              beat_valid,
  output dof_pkg::in_beat_t beat,
  output logic              fire
);

  logic              valid_r;
  logic              valid_nxt;
  dof_pkg::in_beat_t beat_r;
  logic              take;

  assign fire     = valid_r && out_free;
  assign in_stall = valid_r && !out_free;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat_r <= in_beat;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

### hw/rtl/dof_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dof_parser
// Option record walker: parse state registers and the per-beat step logic.
// ----------------------------------------------------------------------------
module dof_parser #(
  parameter int unsigned OPTION_AREA_BYTES = 308
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  dof_pkg::in_beat_t  beat,
  output dof_pkg::step_res_t res
);

  localparam int unsigned IW = dof_pkg::IDX_W;
  localparam int unsigned LW = dof_pkg::LEN_W;
  localparam logic [LW-1:0] OPT_LEN = LW'(OPTION_AREA_BYTES);

  dof_pkg::phase_t ph_r, ph_nxt, cur_ph;
  logic [1:0]      region_r, region_nxt, cur_region;
  logic [IW-1:0]   idx_r, idx_nxt, cur_idx;
  logic [IW-1:0]   nri_r, nri_nxt, cur_nri;
  logic [1:0]      flags_r, flags_nxt;
  logic [7:0]      want_r, want_nxt;
  logic [7:0]      vrem_r, vrem_nxt;

  logic [LW-1:0]   len;
  logic [LW-1:0]   idx_w;
  logic [LW-1:0]   idx_p1;
  logic [LW-1:0]   idx_pb;
  logic [LW-1:0]   idx_pb1;
  logic [7:0]      b;
  logic [1:0]      nr;
  logic            fin;
  logic [1:0]      fin_status;
  logic            have;
  logic            last;
  logic            code_now;
  logic            switched;

  assign b       = beat.data_byte;
  assign idx_w   = {1'b0, cur_idx};
  assign idx_p1  = idx_w + LW'(1);
  assign idx_pb  = idx_w + {4'b0, b};
  assign idx_pb1 = idx_pb + LW'(1);

  always_comb begin
    case (cur_region)
      dof_pkg::REGION_OPTIONS: len = OPT_LEN;
      dof_pkg::REGION_FILE:    len = dof_pkg::FILE_AREA_BYTES;
      default:                 len = dof_pkg::SNAME_AREA_BYTES;
    endcase
  end

  always_comb begin
    if (beat.packet_start) begin
      cur_ph     = dof_pkg::PH_WALK;
      cur_region = dof_pkg::REGION_OPTIONS;
      cur_idx    = '0;
      cur_nri    = '0;
      flags_nxt  = 2'b00;
      vrem_nxt   = 8'd0;
      want_nxt   = beat.search_code;
    end else begin
      cur_ph     = ph_r;
      cur_region = region_r;
      cur_idx    = idx_r;
      cur_nri    = nri_r;
      flags_nxt  = flags_r;
      vrem_nxt   = vrem_r;
      want_nxt   = want_r;
    end
    ph_nxt     = cur_ph;
    region_nxt = cur_region;
    idx_nxt    = cur_idx;
    nri_nxt    = cur_nri;
    fin        = 1'b0;
    fin_status = dof_pkg::ST_VALUE;
    have       = 1'b0;
    last       = 1'b0;
    code_now   = 1'b0;
    switched   = 1'b0;
    nr         = dof_pkg::REGION_OPTIONS;

    if (cur_ph != dof_pkg::PH_IDLE && !(beat.region < cur_region)) begin
      if (beat.region > cur_region || idx_w >= len) begin
        fin        = 1'b1;
        fin_status = dof_pkg::ST_MALFORMED;
      end else begin
        idx_nxt = idx_p1[IW-1:0];
        case (cur_ph)
          dof_pkg::PH_LEN_MATCH: begin
            if (idx_pb >= len) begin
              fin        = 1'b1;
              fin_status = dof_pkg::ST_MALFORMED;
            end else if (b == 8'd0) begin
              fin        = 1'b1;
              fin_status = dof_pkg::ST_EMPTY;
            end else begin
              vrem_nxt = b;
              ph_nxt   = dof_pkg::PH_VALUE;
            end
          end
          dof_pkg::PH_VALUE: begin
            have     = 1'b1;
            vrem_nxt = vrem_nxt - 8'd1;
            if (vrem_nxt == 8'd0) begin
              last   = 1'b1;
              ph_nxt = dof_pkg::PH_IDLE;
            end
          end
          dof_pkg::PH_LEN_SKIP, dof_pkg::PH_LEN_OVER: begin
            if (idx_pb1 >= len) begin
              fin        = 1'b1;
              fin_status = dof_pkg::ST_MALFORMED;
            end else begin
              nri_nxt = idx_pb1[IW-1:0];
              ph_nxt  = (cur_ph == dof_pkg::PH_LEN_OVER) ? dof_pkg::PH_FLAG_OVER
                                                         : dof_pkg::PH_WALK;
            end
          end
          dof_pkg::PH_FLAG_OVER: begin
            flags_nxt = b[1:0];
            ph_nxt    = dof_pkg::PH_WALK;
            code_now  = (cur_idx == cur_nri);
          end
          default: begin
            code_now = (cur_idx >= cur_nri);
          end
        endcase

        if (!fin && code_now) begin
          if (b == want_nxt) begin
            if (idx_p1 >= len) begin
              fin        = 1'b1;
              fin_status = dof_pkg::ST_MALFORMED;
            end else begin
              ph_nxt = dof_pkg::PH_LEN_MATCH;
            end
          end else if (b == dof_pkg::CODE_PAD) begin
            if (idx_p1 >= len) begin
              fin        = 1'b1;
              fin_status = dof_pkg::ST_MALFORMED;
            end else begin
              nri_nxt = idx_p1[IW-1:0];
            end
          end else if (b == dof_pkg::CODE_END) begin
            if (cur_region == dof_pkg::REGION_OPTIONS) begin
              if ((flags_nxt & dof_pkg::OVL_FILE_BIT) != 2'b00) begin
                nr = dof_pkg::REGION_FILE;
              end else if ((flags_nxt & dof_pkg::OVL_SNAME_BIT) != 2'b00) begin
                nr = dof_pkg::REGION_SNAME;
              end
            end else if (cur_region == dof_pkg::REGION_FILE &&
                         (flags_nxt & dof_pkg::OVL_SNAME_BIT) != 2'b00) begin
              nr = dof_pkg::REGION_SNAME;
            end
            if (nr == dof_pkg::REGION_OPTIONS) begin
              fin        = 1'b1;
              fin_status = dof_pkg::ST_NOT_FOUND;
            end else begin
              region_nxt = nr;
              idx_nxt    = '0;
              nri_nxt    = '0;
              switched   = 1'b1;
            end
          end else begin
            if (idx_p1 >= len) begin
              fin        = 1'b1;
              fin_status = dof_pkg::ST_MALFORMED;
            end else begin
              ph_nxt = (b == dof_pkg::CODE_OVERLOAD) ? dof_pkg::PH_LEN_OVER
                                                     : dof_pkg::PH_LEN_SKIP;
            end
          end
        end

        if (!fin && beat.region_last && ph_nxt != dof_pkg::PH_IDLE && !switched) begin
          fin        = 1'b1;
          fin_status = dof_pkg::ST_MALFORMED;
        end
      end
    end

    if (fin) begin
      ph_nxt               = dof_pkg::PH_IDLE;
      vrem_nxt             = 8'd0;
      res.emit             = 1'b1;
      res.beat.value_byte  = 8'd0;
      res.beat.status      = fin_status;
      res.beat.last_result = 1'b1;
    end else begin
      res.emit             = have;
      res.beat.value_byte  = b;
      res.beat.status      = dof_pkg::ST_VALUE;
      res.beat.last_result = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= dof_pkg::PH_IDLE;
      region_r <= dof_pkg::REGION_OPTIONS;
      idx_r    <= '0;
      nri_r    <= '0;
      flags_r  <= 2'b00;
      want_r   <= 8'd0;
      vrem_r   <= 8'd0;
    end else if (fire) begin
      ph_r     <= ph_nxt;
      region_r <= region_nxt;
      idx_r    <= idx_nxt;
      nri_r    <= nri_nxt;
      flags_r  <= flags_nxt;
      want_r   <= want_nxt;
      vrem_r   <= vrem_nxt;
    end
  end

endmodule

### hw/rtl/dof_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dof_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module dof_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  dof_pkg::step_res_t res,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_stall,
  output dof_pkg::out_beat_t out_beat
);

  logic               valid_r;
  logic               valid_nxt;
  dof_pkg::out_beat_t beat_r;
  logic               load;

  assign out_free = !valid_r || !out_stall;
  assign load     = fire && res.emit;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= res.beat;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

### hw/rtl/dhcp_option_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_option_finder
// Searches the option bytes of a dhcp packet for one option code, following
// overload into the file and sname areas.
//
// in channel: one packet byte per beat (options area, then file, then sname),
// tagged with its region; the first beat of a packet carries packet_start and
// the code to look for. out channel: the value bytes of the first matching
// option, the final one with last_result, or one status beat (empty match,
// not found, malformed) with last_result; malformed may also end a value run.
// A result beat shows on out_valid once the beat that causes it has passed the
// input register and the parse step into the result register. Throughput: one
// beat per cycle while the receiver does not stall, set by the parse step.
// When the receiver stalls, the result register holds; the input register can
// still fill once, after which in_stall rises until the result is taken.
// Reset clears both stage valids and returns the parser to idle: bytes are
// ignored until a beat with packet_start arrives.
// ----------------------------------------------------------------------------
module dhcp_option_finder #(
  parameter int unsigned OPTION_AREA_BYTES = 308
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dof_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output dof_pkg::out_beat_t out_beat
);

  logic               out_free;
  logic               beat_valid;
  logic               fire;
  dof_pkg::in_beat_t  beat;
  dof_pkg::step_res_t res;

  dof_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .out_free   (out_free),
    .beat_valid (beat_valid),
    .beat       (beat),
    .fire       (fire)
  );

  dof_parser #(
    .OPTION_AREA_BYTES (OPTION_AREA_BYTES)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire && beat_valid),
    .beat  (beat),
    .res   (res)
  );

  dof_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

### bench/dhcp_option_finder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_option_finder_test
// Self-checking bench for the dhcp option finder. An initial block queues
// packets: a few hand-made ones, then mostly well-formed option walks with
// random records, overload into the file and sname areas, and some broken or
// junk packets. A clocked driver sends them in random bursts, and the receiver
// stalls on its own pattern with repeated long hold-offs. Every accepted byte goes
// through a local model of the option walk, and each result beat is compared
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module dhcp_option_finder_test;

  localparam int unsigned OPTION_BYTES = 308;

  typedef struct packed {
    dof_pkg::in_beat_t beat;
    logic              drain;
  } feed_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  dof_pkg::in_beat_t  in_beat = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dof_pkg::out_beat_t out_beat;

  feed_item_t         byte_feed[$];
  dof_pkg::in_beat_t  pkt[$];
  dof_pkg::out_beat_t predicted_finds[$];
  feed_item_t         next_item;
  dof_pkg::out_beat_t want_beat;
  int         fail_count = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         hold_left = 0;
  logic [31:0] rx_cycle = '0;

  // option walk state
  dof_pkg::phase_t parse_state = dof_pkg::PH_IDLE;
  logic [1:0]  walk_region = dof_pkg::REGION_OPTIONS;
  logic [10:0] walk_idx = '0;
  logic [10:0] record_idx = '0;
  logic [1:0]  ovl_flags = '0;
  logic [7:0]  target_code = '0;
  logic [7:0]  bytes_left = '0;

  dhcp_option_finder #(
    .OPTION_AREA_BYTES(OPTION_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat(out_beat)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned area_len(input logic [1:0] rg);
    if (rg == dof_pkg::REGION_OPTIONS) return OPTION_BYTES;
    if (rg == dof_pkg::REGION_FILE) return 32'(dof_pkg::FILE_AREA_BYTES);
    return 32'(dof_pkg::SNAME_AREA_BYTES);
  endfunction

  task automatic option_walk_step(input dof_pkg::in_beat_t b);
    int unsigned        idx;
    int unsigned        len;
    int unsigned        nxt;
    int unsigned        byt;
    logic [1:0]         nr;
    bit                 has_nr;
    bit                 have;
    bit                 last;
    bit                 switched;
    bit                 code_now;
    bit                 done;
    logic [1:0]         st;
    dof_pkg::out_beat_t r;
    have = 1'b0;
    last = 1'b0;
    switched = 1'b0;
    code_now = 1'b0;
    done = 1'b0;
    st = dof_pkg::ST_VALUE;
    byt = 32'(b.data_byte);
    if (b.packet_start) begin
      parse_state = dof_pkg::PH_WALK;
      walk_region = dof_pkg::REGION_OPTIONS;
      walk_idx = '0;
      record_idx = '0;
      ovl_flags = '0;
      bytes_left = '0;
      target_code = b.search_code;
    end
    if (parse_state == dof_pkg::PH_IDLE || b.region < walk_region) return;
    idx = 32'(walk_idx);
    len = area_len(walk_region);
    if (b.region > walk_region || idx >= len) begin
      st = dof_pkg::ST_MALFORMED;
      done = 1'b1;
    end else begin
      walk_idx = 11'(idx + 1);
      case (parse_state)
        dof_pkg::PH_LEN_MATCH: begin
          if (idx + byt >= len) begin
            st = dof_pkg::ST_MALFORMED;
            done = 1'b1;
          end else if (byt == 0) begin
            st = dof_pkg::ST_EMPTY;
            done = 1'b1;
          end else begin
            bytes_left = b.data_byte;
            parse_state = dof_pkg::PH_VALUE;
          end
        end
        dof_pkg::PH_VALUE: begin
          have = 1'b1;
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 0) begin
            last = 1'b1;
            parse_state = dof_pkg::PH_IDLE;
          end
        end
        dof_pkg::PH_LEN_SKIP, dof_pkg::PH_LEN_OVER: begin
          nxt = idx + byt + 1;
          if (nxt >= len) begin
            st = dof_pkg::ST_MALFORMED;
            done = 1'b1;
          end else begin
            record_idx = 11'(nxt);
            parse_state = (parse_state == dof_pkg::PH_LEN_OVER) ? dof_pkg::PH_FLAG_OVER
                                                                : dof_pkg::PH_WALK;
          end
        end
        dof_pkg::PH_FLAG_OVER: begin
          ovl_flags = b.data_byte[1:0];
          parse_state = dof_pkg::PH_WALK;
          code_now = (idx == record_idx);
        end
        default: begin
          code_now = (idx >= record_idx);
        end
      endcase
      if (!done && code_now) begin
        if (b.data_byte == target_code) begin
          if (idx + 1 >= len) begin
            st = dof_pkg::ST_MALFORMED;
            done = 1'b1;
          end else begin
            parse_state = dof_pkg::PH_LEN_MATCH;
          end
        end else if (b.data_byte == dof_pkg::CODE_PAD) begin
          if (idx + 1 >= len) begin
            st = dof_pkg::ST_MALFORMED;
            done = 1'b1;
          end else begin
            record_idx = 11'(idx + 1);
          end
        end else if (b.data_byte == dof_pkg::CODE_END) begin
          has_nr = 1'b0;
          nr = dof_pkg::REGION_OPTIONS;
          if (walk_region == dof_pkg::REGION_OPTIONS) begin
            if ((ovl_flags & dof_pkg::OVL_FILE_BIT) != 0) begin
              has_nr = 1'b1;
              nr = dof_pkg::REGION_FILE;
            end else if ((ovl_flags & dof_pkg::OVL_SNAME_BIT) != 0) begin
              has_nr = 1'b1;
              nr = dof_pkg::REGION_SNAME;
            end
          end else if (walk_region == dof_pkg::REGION_FILE &&
                       (ovl_flags & dof_pkg::OVL_SNAME_BIT) != 0) begin
            has_nr = 1'b1;
            nr = dof_pkg::REGION_SNAME;
          end
          if (!has_nr) begin
            st = dof_pkg::ST_NOT_FOUND;
            done = 1'b1;
          end else begin
            walk_region = nr;
            walk_idx = '0;
            record_idx = '0;
            switched = 1'b1;
          end
        end else begin
          if (idx + 1 >= len) begin
            st = dof_pkg::ST_MALFORMED;
            done = 1'b1;
          end else begin
            parse_state = (b.data_byte == dof_pkg::CODE_OVERLOAD) ? dof_pkg::PH_LEN_OVER
                                                                  : dof_pkg::PH_LEN_SKIP;
          end
        end
      end
      if (!done && b.region_last && parse_state != dof_pkg::PH_IDLE && !switched) begin
        st = dof_pkg::ST_MALFORMED;
        done = 1'b1;
      end
    end
    if (done) begin
      parse_state = dof_pkg::PH_IDLE;
      bytes_left = '0;
      r.value_byte = 8'd0;
      r.status = st;
      r.last_result = 1'b1;
      predicted_finds.push_back(r);
    end else if (have) begin
      r.value_byte = b.data_byte;
      r.status = dof_pkg::ST_VALUE;
      r.last_result = last;
      predicted_finds.push_back(r);
    end
  endtask

  task automatic put(input logic [7:0] d, input logic [1:0] rg);
    dof_pkg::in_beat_t b;
    b.data_byte = d;
    b.region = rg;
    b.packet_start = 1'b0;
    b.region_last = 1'b0;
    b.search_code = 8'($urandom_range(0, 255));
    pkt.push_back(b);
  endtask

  task automatic mark_last(input int k);
    dof_pkg::in_beat_t b;
    b = pkt[k];
    b.region_last = 1'b1;
    pkt[k] = b;
  endtask

  task automatic queue_packet(input bit started, input logic [7:0] w, input bit drain);
    feed_item_t p;
    for (int k = 0; k < pkt.size(); k++) begin
      p.beat = pkt[k];
      p.drain = drain && (k == 0);
      if (k == 0 && started) begin
        p.beat.packet_start = 1'b1;
        p.beat.search_code = w;
      end
      byte_feed.push_back(p);
    end
    pkt.delete();
  endtask

  // records of one area, closed by the wanted option or the end option
  task automatic add_records(input logic [1:0] rg, input logic [7:0] w,
                             output bit matched, inout logic [1:0] flags);
    int         n;
    int         len;
    logic [7:0] c;
    logic [7:0] f;
    matched = 1'b0;
    n = $urandom_range(0, 5);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0, 3: put(dof_pkg::CODE_PAD, rg);
        1: begin
          c = 8'($urandom_range(1, 253));
          if (c == w || c == dof_pkg::CODE_OVERLOAD) c = 8'd1;
          len = $urandom_range(0, 6);
          put(c, rg);
          put(8'(len), rg);
          repeat (len) put(8'($urandom_range(0, 255)), rg);
        end
        default: begin
          len = $urandom_range(0, 3);
          put(dof_pkg::CODE_OVERLOAD, rg);
          put(8'(len), rg);
          if (len == 0) begin
            f = 8'($urandom_range(1, 3));
            flags = f[1:0];
            put(f, rg);
            put(8'd0, rg);
          end else begin
            f = 8'($urandom_range(0, 255));
            flags = f[1:0];
            put(f, rg);
            repeat (len - 1) put(8'($urandom_range(0, 255)), rg);
          end
        end
      endcase
    end
    if ($urandom_range(0, 2) == 0) begin
      len = $urandom_range(0, 6);
      put(w, rg);
      put(8'(len), rg);
      repeat (len) put(8'($urandom_range(0, 255)), rg);
      matched = 1'b1;
    end else begin
      put(dof_pkg::CODE_END, rg);
    end
    if ($urandom_range(0, 1) == 1) mark_last(pkt.size() - 1);
  endtask

  task automatic build_clean(output logic [7:0] w);
    bit         matched;
    logic [1:0] flags;
    w = 8'($urandom_range(4, 254));
    if (w == dof_pkg::CODE_OVERLOAD) w = 8'd53;
    flags = 2'b00;
    add_records(dof_pkg::REGION_OPTIONS, w, matched, flags);
    if (!matched && flags != 0) begin
      repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)), dof_pkg::REGION_OPTIONS);
      if (flags[0]) add_records(dof_pkg::REGION_FILE, w, matched, flags);
      if (!matched && flags[1]) add_records(dof_pkg::REGION_SNAME, w, matched, flags);
    end
  endtask

  task automatic mangle(input logic [7:0] w);
    int                i;
    dof_pkg::in_beat_t b;
    i = $urandom_range(0, pkt.size() - 1);
    b = pkt[i];
    case ($urandom_range(0, 4))
      0: begin
        while (pkt.size() > i + 1) void'(pkt.pop_back());
        b.region_last = 1'($urandom_range(0, 1));
        pkt[i] = b;
      end
      1: begin
        b.region = 2'($urandom_range(0, 3));
        pkt[i] = b;
      end
      2: begin
        b.data_byte = 8'($urandom_range(0, 255));
        pkt[i] = b;
      end
      3: begin
        pkt.delete();
        put(w, dof_pkg::REGION_OPTIONS);
        put(8'($urandom_range(200, 255)), dof_pkg::REGION_OPTIONS);
        repeat (4) put(8'($urandom_range(0, 255)), dof_pkg::REGION_OPTIONS);
      end
      default: begin
        b.region_last = 1'b1;
        pkt[i] = b;
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_beat <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) option_walk_step(in_beat);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (byte_feed.size() > 0 &&
                     !(byte_feed[0].drain && predicted_finds.size() > 0)) begin
          next_item = byte_feed.pop_front();
          in_beat <= next_item.beat;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_cycle <= '0;
      hold_left <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (rx_cycle % 1100 == 300) begin
        hold_left <= 120;
        out_stall <= 1'b1;
      end else begin
        case (rx_cycle[7:6])
          2'd0: out_stall <= 1'b0;
          2'd1: out_stall <= ($urandom_range(0, 3) == 0);
          2'd2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (rx_cycle[2:0] < 3'd3);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_finds.size() == 0) begin
        $error("result beat with none predicted: value_byte %0d status %0d last_result %0d",
               out_beat.value_byte, out_beat.status, out_beat.last_result);
        fail_count++;
      end else begin
        want_beat = predicted_finds.pop_front();
        if (out_beat.value_byte !== want_beat.value_byte) begin
          $error("value_byte: expected %0d, actual %0d", want_beat.value_byte,
                 out_beat.value_byte);
          fail_count++;
        end
        if (out_beat.status !== want_beat.status) begin
          $error("status: expected %0d, actual %0d", want_beat.status, out_beat.status);
          fail_count++;
        end
        if (out_beat.last_result !== want_beat.last_result) begin
          $error("last_result: expected %0d, actual %0d", want_beat.last_result,
                 out_beat.last_result);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [7:0] w;
    int         item_total;
    int         pkt_count;
    int         kind;
    logic [7:0] tail;

    // bytes before any packet start are ignored
    put(8'hFF, dof_pkg::REGION_OPTIONS);
    put(8'h00, 2'd3);
    queue_packet(1'b0, 8'd0, 1'b0);
    // wanted code 0 matches a pad byte
    put(dof_pkg::CODE_PAD, dof_pkg::REGION_OPTIONS);
    put(8'd2, dof_pkg::REGION_OPTIONS);
    put(8'hAA, dof_pkg::REGION_OPTIONS);
    put(8'hFF, dof_pkg::REGION_OPTIONS);
    queue_packet(1'b1, dof_pkg::CODE_PAD, 1'b0);
    // wanted code 255 matches the end byte, zero length
    put(dof_pkg::CODE_END, dof_pkg::REGION_OPTIONS);
    put(8'd0, dof_pkg::REGION_OPTIONS);
    queue_packet(1'b1, dof_pkg::CODE_END, 1'b0);
    // pad then end, no overload
    put(dof_pkg::CODE_PAD, dof_pkg::REGION_OPTIONS);
    put(dof_pkg::CODE_END, dof_pkg::REGION_OPTIONS);
    queue_packet(1'b1, 8'h80, 1'b0);
    // byte of region 3
    put(8'd5, 2'd3);
    queue_packet(1'b1, 8'd5, 1'b0);
    // region ends inside a record
    put(8'd7, dof_pkg::REGION_OPTIONS);
    mark_last(0);
    queue_packet(1'b1, 8'd6, 1'b0);
    // overload with zero length, then a match in the file area
    put(dof_pkg::CODE_OVERLOAD, dof_pkg::REGION_OPTIONS);
    put(8'd0, dof_pkg::REGION_OPTIONS);
    put(8'd3, dof_pkg::REGION_OPTIONS);
    put(8'd0, dof_pkg::REGION_OPTIONS);
    put(dof_pkg::CODE_END, dof_pkg::REGION_OPTIONS);
    mark_last(4);
    put(8'd9, dof_pkg::REGION_FILE);
    put(8'd1, dof_pkg::REGION_FILE);
    put(8'h80, dof_pkg::REGION_FILE);
    mark_last(7);
    queue_packet(1'b1, 8'd9, 1'b0);

    item_total = 20;
    pkt_count = 0;
    while (item_total < 650) begin
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
        // sname walk that runs to the last byte of the area
        w = 8'($urandom_range(4, 254));
        if (w == dof_pkg::CODE_OVERLOAD) w = 8'd53;
        tail = 8'($urandom_range(0, 63));
        put(dof_pkg::CODE_OVERLOAD, dof_pkg::REGION_OPTIONS);
        put(8'd1, dof_pkg::REGION_OPTIONS);
        put({tail[5:0], 2'b10}, dof_pkg::REGION_OPTIONS);
        put(dof_pkg::CODE_END, dof_pkg::REGION_OPTIONS);
        repeat (63) put(dof_pkg::CODE_PAD, dof_pkg::REGION_SNAME);
        case ($urandom_range(0, 2))
          0: put(dof_pkg::CODE_PAD, dof_pkg::REGION_SNAME);
          1: put(w, dof_pkg::REGION_SNAME);
          default: put(8'd7, dof_pkg::REGION_SNAME);
        endcase
        mark_last(pkt.size() - 1);
      end else if (kind < 12) begin
        case ($urandom_range(0, 3))
          0: w = dof_pkg::CODE_PAD;
          1: w = dof_pkg::CODE_OVERLOAD;
          2: w = dof_pkg::CODE_END;
          default: w = 8'($urandom_range(0, 255));
        endcase
        repeat ($urandom_range(1, 12)) begin
          put(8'($urandom_range(0, 255)),
              ($urandom_range(0, 9) < 8) ? dof_pkg::REGION_OPTIONS
                                         : 2'($urandom_range(0, 3)));
          if ($urandom_range(0, 9) == 0) mark_last(pkt.size() - 1);
        end
      end else begin
        build_clean(w);
        if (kind < 30) mangle(w);
      end
      item_total += pkt.size();
      repeat ($urandom_range(0, 2)) begin
        put(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 1) == 1) mark_last(pkt.size() - 1);
      end
      queue_packet(1'b1, w, (pkt_count == 6) || ($urandom_range(0, 19) == 0));
      pkt_count++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (byte_feed.size() > 0 || in_valid) @(posedge clk);
    while (predicted_finds.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### dhcp_option_finder.f
hw/rtl/dof_pkg.sv
hw/rtl/dof_in_stage.sv
hw/rtl/dof_parser.sv
hw/rtl/dof_out_stage.sv
hw/rtl/dhcp_option_finder.sv
bench/dhcp_option_finder_test.sv
